[design/ugnq_pkg.sv]
`timescale 1ns / 1ps
package ugnq_pkg;

   // request codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_RADIUS = 2'd2;
   localparam logic [1:0] OP_RECT   = 2'd3;

   // register indexes
   localparam logic CSR_SMALL_RADIUS = 1'b0;
   localparam logic CSR_LARGE_RADIUS = 1'b1;

   localparam int DEF_GRID_WIDTH   = 16;
   localparam int DEF_GRID_HEIGHT  = 16;
   localparam int DEF_MAX_ENTITIES = 64;
   localparam int DEF_CELL_SHIFT   = 10;

   localparam int HIT_CAP = 64;
   localparam int HIT_W   = 7;
   localparam int IDX_W   = 6;
   localparam int CORD_W  = 6;
   localparam int EXT_W   = 15;
   localparam int POS_W   = 16;

   localparam logic [EXT_W-1:0] SMALL_RADIUS_RST = 15'd320;
   localparam logic [EXT_W-1:0] LARGE_RADIUS_RST = 15'd560;

   // command from front to back
   typedef struct packed {
      logic [1:0]              op;
      logic [IDX_W-1:0]        idx;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic                    big;
      logic [EXT_W-1:0]        w;
      logic [EXT_W-1:0]        h;
      logic [CORD_W-1:0]       x0;
      logic [CORD_W-1:0]       x1;
      logic [CORD_W-1:0]       y0;
      logic [CORD_W-1:0]       y1;
      logic                    none;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic [IDX_W-1:0] hit_index;
      logic             hit_valid;
      logic             last;
   } rsp_type;

endpackage

[design/ugnq_ram.sv]
`timescale 1ns / 1ps
module ugnq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH>1?DEPTH:2)-1:0] addr,
   input  logic [WIDTH-1:0]                 wdata,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

[design/ugnq_fifo.sv]
`timescale 1ns / 1ps
module ugnq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (PW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   // pointer update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule

[design/ugnq_front.sv]
`timescale 1ns / 1ps
module ugnq_front #(
   parameter int GRID_WIDTH   = ugnq_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT  = ugnq_pkg::DEF_GRID_HEIGHT,
   parameter int MAX_ENTITIES = ugnq_pkg::DEF_MAX_ENTITIES,
   parameter int CELL_SHIFT   = ugnq_pkg::DEF_CELL_SHIFT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_type,
   input  logic [5:0]            req_ent_index,
   input  logic signed [15:0]    req_pos_x,
   input  logic signed [15:0]    req_pos_y,
   input  logic                  req_ent_alive,
   input  logic                  req_ent_large,
   input  logic [14:0]           req_extent_w,
   input  logic [14:0]           req_extent_h,
   input  logic                  cmd_pop,
   output logic                  cmd_empty,
   output ugnq_pkg::cmd_type     cmd
);
   import ugnq_pkg::*;

   // lower bound: negative clamps to zero, flag when past the grid
   function automatic logic [CORD_W:0] lo_cell(logic signed [17:0] v, int n);
      logic [17:0] sh;
      sh = 18'(v >>> CELL_SHIFT);
      if (v < 0) begin
         lo_cell = '0;
      end else if (sh > 18'(n - 1)) begin
         lo_cell = {1'b1, CORD_W'(n - 1)};
      end else begin
         lo_cell = {1'b0, sh[CORD_W-1:0]};
      end
   endfunction

   // upper bound: truncation toward zero, flag when below cell zero
   function automatic logic [CORD_W:0] hi_cell(logic signed [17:0] v, int n);
      logic [17:0] sh;
      sh = 18'(v >>> CELL_SHIFT);
      if (v <= -(18'sd1 <<< CELL_SHIFT)) begin
         hi_cell = {1'b1, CORD_W'(0)};
      end else if (v < 0) begin
         hi_cell = '0;
      end else if (sh > 18'(n - 1)) begin
         hi_cell = {1'b0, CORD_W'(n - 1)};
      end else begin
         hi_cell = {1'b0, sh[CORD_W-1:0]};
      end
   endfunction

   logic signed [17:0] px, py, w, h, xa, xb, ya, yb;
   logic [CORD_W:0]    lx, hx, ly, hy;
   cmd_type            cmd_in;
   logic               take;

   assign px = 18'(req_pos_x);
   assign py = 18'(req_pos_y);
   assign w  = {3'b000, req_extent_w};
   assign h  = {3'b000, req_extent_h};

   // covered range per request kind
   always_comb begin
      xa = px;
      xb = px;
      ya = py;
      yb = py;
      case (req_type)
         OP_RADIUS: begin
            xa = px - w;
            xb = px + w;
            ya = py - w;
            yb = py + w;
         end
         OP_RECT: begin
            xb = px + w;
            yb = py + h;
         end
         default: begin
         end
      endcase
      lx = lo_cell(xa, GRID_WIDTH);
      ly = lo_cell(ya, GRID_HEIGHT);
      hx = hi_cell(xb, GRID_WIDTH);
      hy = hi_cell(yb, GRID_HEIGHT);
   end

   // classified command
   always_comb begin
      cmd_in.op    = req_type;
      cmd_in.idx   = req_ent_index;
      cmd_in.px    = req_pos_x;
      cmd_in.py    = req_pos_y;
      cmd_in.big   = req_ent_large;
      cmd_in.w     = req_extent_w;
      cmd_in.h     = req_extent_h;
      cmd_in.x0    = lx[CORD_W-1:0];
      cmd_in.y0    = ly[CORD_W-1:0];
      cmd_in.x1    = hx[CORD_W-1:0];
      cmd_in.y1    = hy[CORD_W-1:0];
      cmd_in.none  = lx[CORD_W] || ly[CORD_W] || hx[CORD_W] || hy[CORD_W] ||
                     (lx[CORD_W-1:0] > hx[CORD_W-1:0]) ||
                     (ly[CORD_W-1:0] > hy[CORD_W-1:0]);
   end

   // inserts that change nothing are dropped here
   assign take = req_push && ((req_type != OP_INSERT) ||
                 (req_ent_alive && (32'(req_ent_index) < MAX_ENTITIES)));

   logic cmd_full;
   assign req_full = cmd_full;

   ugnq_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_cmdq (
      .clock(clock),
      .reset(reset),
      .push (take),
      .wdata(cmd_in),
      .full (cmd_full),
      .pop  (cmd_pop),
      .empty(cmd_empty),
      .rdata(cmd)
   );
endmodule

[design/ugnq_back.sv]
`timescale 1ns / 1ps
module ugnq_back #(
   parameter int GRID_WIDTH   = ugnq_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT  = ugnq_pkg::DEF_GRID_HEIGHT,
   parameter int MAX_ENTITIES = ugnq_pkg::DEF_MAX_ENTITIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [14:0]        csr_wdata,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   input  ugnq_pkg::cmd_type  cmd,
   output logic               out_push,
   input  logic               out_full,
   output ugnq_pkg::rsp_type  out_item
);
   import ugnq_pkg::*;

   localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
   localparam int CI_W   = $clog2(NCELLS > 1 ? NCELLS : 2);
   localparam int EA_W   = $clog2(NCELLS * MAX_ENTITIES > 1 ? NCELLS * MAX_ENTITIES : 2);
   localparam int EN_W   = $clog2(MAX_ENTITIES > 1 ? MAX_ENTITIES : 2);
   localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
   localparam int ENT_DW = 2 * POS_W + 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INS_A = 4'd1;
   localparam logic [3:0] ST_INS_B = 4'd2;
   localparam logic [3:0] ST_C_A   = 4'd3;
   localparam logic [3:0] ST_C_B   = 4'd4;
   localparam logic [3:0] ST_E_A   = 4'd5;
   localparam logic [3:0] ST_E_B   = 4'd6;
   localparam logic [3:0] ST_T1    = 4'd7;
   localparam logic [3:0] ST_T2    = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;

   logic [3:0]         st_ff, st_in;
   cmd_type            cmd_ff;
   logic [CORD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [CNT_W-1:0]   k_ff, k_in, cnt_ff, cnt_in;
   logic [HIT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   pend_ff, pend_in, e_ff, e_in;
   logic               pv_ff, pv_in;
   logic [NCELLS-1:0]  valid_ff, valid_in;
   logic [EXT_W-1:0]   small_r_ff, large_r_ff;
   logic [33:0]        dx2_ff, dy2_ff;
   logic [29:0]        w2_ff;
   logic               rhit_ff;

   logic [CI_W-1:0]    cell_idx;
   logic [CNT_W-1:0]   cur_cnt;
   logic [EA_W-1:0]    ent_addr;
   logic               cnt_we, ent_we, pos_we;
   logic [CNT_W-1:0]   cnt_rd;
   logic [IDX_W-1:0]   ent_rd;
   logic [ENT_DW-1:0]  pos_rd;
   logic [EN_W-1:0]    pos_addr;
   logic               hit, last_cell, last_k;

   // cell and list addresses
   assign cell_idx = CI_W'(32'(cx_ff) * GRID_HEIGHT + 32'(cy_ff));
   assign cur_cnt  = valid_ff[cell_idx] ? cnt_rd : '0;
   assign ent_addr = EA_W'(32'(cell_idx) * MAX_ENTITIES +
                     32'((st_ff == ST_INS_B) ? cur_cnt : k_ff));
   assign cnt_we   = (st_ff == ST_INS_B) && (32'(cur_cnt) < MAX_ENTITIES);
   assign ent_we   = cnt_we;
   assign pos_we   = (st_ff == ST_INS_A);
   assign pos_addr = (st_ff == ST_INS_A) ? cmd_ff.idx[EN_W-1:0] : ent_rd[EN_W-1:0];

   ugnq_ram #(.WIDTH(CNT_W), .DEPTH(NCELLS)) u_count (
      .clock(clock), .we(cnt_we), .addr(cell_idx),
      .wdata(cur_cnt + 1'b1), .rdata(cnt_rd)
   );

   ugnq_ram #(.WIDTH(IDX_W), .DEPTH(NCELLS * MAX_ENTITIES)) u_entries (
      .clock(clock), .we(ent_we), .addr(ent_addr),
      .wdata(cmd_ff.idx), .rdata(ent_rd)
   );

   ugnq_ram #(.WIDTH(ENT_DW), .DEPTH(MAX_ENTITIES)) u_pos (
      .clock(clock), .we(pos_we), .addr(pos_addr),
      .wdata({cmd_ff.big, cmd_ff.px, cmd_ff.py}), .rdata(pos_rd)
   );

   // hit tests on the stored position
   logic signed [POS_W-1:0] ex, ey;
   logic                    el;
   logic signed [17:0]      dx, dy, rr, qx, qy, qx1, qy1;
   logic signed [16:0]      dxs, dys;
   assign {el, ex, ey} = pos_rd;
   always_comb begin
      dx  = 18'(ex) - 18'(cmd_ff.px);
      dy  = 18'(ey) - 18'(cmd_ff.py);
      rr  = {3'b000, el ? large_r_ff : small_r_ff};
      qx  = 18'(cmd_ff.px);
      qy  = 18'(cmd_ff.py);
      qx1 = qx + {3'b000, cmd_ff.w};
      qy1 = qy + {3'b000, cmd_ff.h};
   end

   // offsets fit in 17 signed bits
   assign dxs = dx[16:0];
   assign dys = dy[16:0];

   always_ff @(posedge clock) begin
      if (st_ff == ST_T1) begin
         dx2_ff  <= 34'(dxs * dxs);
         dy2_ff  <= 34'(dys * dys);
         w2_ff   <= cmd_ff.w * cmd_ff.w;
         rhit_ff <= (18'(ex) + rr >= qx) && (18'(ex) - rr <= qx1) &&
                    (18'(ey) + rr >= qy) && (18'(ey) - rr <= qy1);
      end
   end

   assign hit = (cmd_ff.op == OP_RADIUS) ?
                ({1'b0, dx2_ff} + {1'b0, dy2_ff} <= 35'(w2_ff)) : rhit_ff;
   assign last_k    = (k_ff + 1'b1 == cnt_ff);
   assign last_cell = (cy_ff == cmd_ff.y1) && (cx_ff == cmd_ff.x1);

   // sequencer
   always_comb begin
      st_in    = st_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      pend_in  = pend_ff;
      pv_in    = pv_ff;
      e_in     = e_ff;
      valid_in = valid_ff;
      cmd_pop  = 1'b0;
      out_push = 1'b0;
      out_item = '{hit_index: pend_ff, hit_valid: 1'b1, last: 1'b0};
      case (st_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cx_in   = cmd.x0;
               cy_in   = cmd.y0;
               n_in    = '0;
               pv_in   = 1'b0;
               case (cmd.op)
                  OP_CLEAR:  valid_in = '0;
                  OP_INSERT: st_in = ST_INS_A;
                  default:   st_in = cmd.none ? ST_FIN : ST_C_A;
               endcase
            end
         end
         ST_INS_A: st_in = ST_INS_B;
         ST_INS_B: begin
            if (cnt_we) begin
               valid_in[cell_idx] = 1'b1;
            end
            st_in = ST_IDLE;
         end
         ST_C_A: st_in = ST_C_B;
         ST_C_B: begin
            cnt_in = cur_cnt;
            k_in   = '0;
            if (cur_cnt == '0) begin
               if (last_cell) begin
                  st_in = ST_FIN;
               end else begin
                  st_in = ST_C_A;
                  if (cy_ff == cmd_ff.y1) begin
                     cy_in = cmd_ff.y0;
                     cx_in = cx_ff + 1'b1;
                  end else begin
                     cy_in = cy_ff + 1'b1;
                  end
               end
            end else begin
               st_in = ST_E_A;
            end
         end
         ST_E_A: st_in = ST_E_B;
         ST_E_B: begin
            e_in  = ent_rd;
            st_in = ST_T1;
         end
         ST_T1: st_in = ST_T2;
         ST_T2: begin
            if (!(hit && pv_ff && out_full)) begin
               if (hit) begin
                  out_push = pv_ff;
                  pend_in  = e_ff;
                  pv_in    = 1'b1;
                  n_in     = n_ff + 1'b1;
               end
               if (hit && (32'(n_ff) + 1 == HIT_CAP)) begin
                  st_in = ST_FIN;
               end else if (!last_k) begin
                  k_in  = k_ff + 1'b1;
                  st_in = ST_E_A;
               end else if (last_cell) begin
                  st_in = ST_FIN;
               end else begin
                  st_in = ST_C_A;
                  if (cy_ff == cmd_ff.y1) begin
                     cy_in = cmd_ff.y0;
                     cx_in = cx_ff + 1'b1;
                  end else begin
                     cy_in = cy_ff + 1'b1;
                  end
               end
            end
         end
         ST_FIN: begin
            out_item = pv_ff ? '{hit_index: pend_ff, hit_valid: 1'b1, last: 1'b1}
                             : '{hit_index: '0, hit_valid: 1'b0, last: 1'b1};
            if (!out_full) begin
               out_push = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         valid_ff <= '0;
         pv_ff    <= 1'b0;
         n_ff     <= '0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= valid_in;
         pv_ff    <= pv_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      pend_ff <= pend_in;
      e_ff    <= e_in;
      if (cmd_pop) begin
         cmd_ff <= cmd;
      end
   end

   // radius registers
   always_ff @(posedge clock) begin
      if (reset) begin
         small_r_ff <= SMALL_RADIUS_RST;
         large_r_ff <= LARGE_RADIUS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SMALL_RADIUS: small_r_ff <= csr_wdata;
            CSR_LARGE_RADIUS: large_r_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // checks
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(out_push && out_full)) else $error("result pushed into full queue");
   a_k_in_list: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_E_A) |-> (k_ff < cnt_ff)) else $error("entry index past list");
   a_hit_cap: assert property (@(posedge clock) disable iff (reset)
      32'(n_ff) <= HIT_CAP) else $error("hit count over cap");
   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FIN && !out_full) |=> (st_ff == ST_IDLE))
      else $error("final item did not finish query");
endmodule

[design/uniform_grid_neighbor_query.sv]
`timescale 1ns / 1ps
// uniform grid neighbor query
// Requests enter through a queue-like port: drive the fields and push while
// full is low. Kinds are clear, insert, radius query and rectangle query.
// Clear and insert give no results; a query gives one or more result items,
// the final one marked by last, and a query with no hit gives a single item
// with hit_valid low. Results wait in a four-entry queue: read them while
// empty is low and pop to take one.
// A front stage computes the covered cell range and feeds a two-entry
// command queue, so requests are taken while the back stage still works.
// Clear is done in idle, insert in INS_A and INS_B. A query steps through
// C_A and C_B per covered cell and E_A, E_B, T1, T2 per stored entry, then
// FIN, paced by registered count, list and position memory reads in series.
// Reset empties both queues, marks every cell list empty and loads the
// default radii; no clearing pass is needed. When results are not popped
// the back stage halts once the result queue is full and the command queue
// then fills and raises full.
module uniform_grid_neighbor_query #(
   parameter int GRID_WIDTH   = ugnq_pkg::DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT  = ugnq_pkg::DEF_GRID_HEIGHT,
   parameter int MAX_ENTITIES = ugnq_pkg::DEF_MAX_ENTITIES,
   parameter int CELL_SHIFT   = ugnq_pkg::DEF_CELL_SHIFT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_type,
   input  logic [5:0]         req_ent_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic               req_ent_alive,
   input  logic               req_ent_large,
   input  logic [14:0]        req_extent_w,
   input  logic [14:0]        req_extent_h,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [5:0]         rsp_hit_index,
   output logic               rsp_hit_valid,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [14:0]        csr_wdata
);
   import ugnq_pkg::*;

   cmd_type cmd;
   rsp_type out_item, rsp;
   logic    cmd_pop, cmd_empty, out_push, out_full;

   ugnq_front #(
      .GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT),
      .MAX_ENTITIES(MAX_ENTITIES), .CELL_SHIFT(CELL_SHIFT)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_type(req_type),
      .req_ent_index(req_ent_index), .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y), .req_ent_alive(req_ent_alive),
      .req_ent_large(req_ent_large), .req_extent_w(req_extent_w),
      .req_extent_h(req_extent_h),
      .cmd_pop(cmd_pop), .cmd_empty(cmd_empty), .cmd(cmd)
   );

   ugnq_back #(
      .GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT),
      .MAX_ENTITIES(MAX_ENTITIES)
   ) u_back (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cmd_empty(cmd_empty), .cmd_pop(cmd_pop), .cmd(cmd),
      .out_push(out_push), .out_full(out_full), .out_item(out_item)
   );

   // result queue
   ugnq_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(4)) u_rspq (
      .clock(clock), .reset(reset),
      .push(out_push), .wdata(out_item), .full(out_full),
      .pop(rsp_pop), .empty(rsp_empty), .rdata(rsp)
   );

   assign rsp_hit_index = rsp.hit_index;
   assign rsp_hit_valid = rsp.hit_valid;
   assign rsp_last      = rsp.last;
endmodule

[test/ugnq_checker.sv]
`timescale 1ns / 1ps
module ugnq_checker
   import ugnq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_type,
   input  logic [5:0]         req_ent_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic               req_ent_alive,
   input  logic               req_ent_large,
   input  logic [14:0]        req_extent_w,
   input  logic [14:0]        req_extent_h,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [5:0]         rsp_hit_index,
   input  logic               rsp_hit_valid,
   input  logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [14:0]        csr_wdata,
   output int                 errors,
   output int                 pending
);

   localparam int GW    = DEF_GRID_WIDTH;
   localparam int GH    = DEF_GRID_HEIGHT;
   localparam int NENT  = DEF_MAX_ENTITIES;
   localparam int SHIFT = DEF_CELL_SHIFT;

   // shadow copy of the grid
   int       small_rad, large_rad;
   int       list_len [GW*GH];
   int       list_ent [GW*GH][NENT];
   int       ent_x [NENT];
   int       ent_y [NENT];
   bit       ent_big [NENT];
   rsp_type  hits_due [$];

   assign pending = hits_due.size();

   // cell coordinate, truncated toward zero, not clamped
   function automatic int cell_coord(int v);
      if (v >= 0) return v >>> SHIFT;
      return -((-v) >>> SHIFT);
   endfunction

   task automatic grid_update(logic [1:0] op, int idx, int px, int py, bit alive,
                              bit big, int w, int h);
      int      x0, x1, y0, y1, cx, cy, c, k, e, n, r;
      longint  dx, dy;
      bit      hit;
      rsp_type item;
      n = 0;
      case (op)
         OP_CLEAR: begin
            foreach (list_len[i]) list_len[i] = 0;
         end
         OP_INSERT: begin
            if (alive) begin
               ent_x[idx] = px;
               ent_y[idx] = py;
               ent_big[idx] = big;
               cx = cell_coord(px);
               cx = cx < 0 ? 0 : (cx >= GW ? GW - 1 : cx);
               cy = cell_coord(py);
               cy = cy < 0 ? 0 : (cy >= GH ? GH - 1 : cy);
               c = cx * GH + cy;
               // a full cell keeps the position but drops the index
               if (list_len[c] < NENT) begin
                  list_ent[c][list_len[c]] = idx;
                  list_len[c]++;
               end
            end
         end
         default: begin
            if (op == OP_RADIUS) begin
               x0 = cell_coord(px - w); x1 = cell_coord(px + w);
               y0 = cell_coord(py - w); y1 = cell_coord(py + w);
            end else begin
               x0 = cell_coord(px); x1 = cell_coord(px + w);
               y0 = cell_coord(py); y1 = cell_coord(py + h);
            end
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 >= GW) x1 = GW - 1;
            if (y1 >= GH) y1 = GH - 1;
            // x outer, y inner, lists in insertion order, capped hits
            for (cx = x0; cx <= x1 && n < HIT_CAP; cx++)
               for (cy = y0; cy <= y1 && n < HIT_CAP; cy++) begin
                  c = cx * GH + cy;
                  for (k = 0; k < list_len[c] && n < HIT_CAP; k++) begin
                     e = list_ent[c][k];
                     if (op == OP_RADIUS) begin
                        dx = longint'(ent_x[e]) - px;
                        dy = longint'(ent_y[e]) - py;
                        hit = dx * dx + dy * dy <= longint'(w) * w;
                     end else begin
                        r = ent_big[e] ? large_rad : small_rad;
                        hit = ent_x[e] + r >= px && ent_x[e] - r <= px + w &&
                              ent_y[e] + r >= py && ent_y[e] - r <= py + h;
                     end
                     if (hit) begin
                        item.hit_index = e[5:0];
                        item.hit_valid = 1'b1;
                        item.last = (n == HIT_CAP - 1);
                        hits_due.push_back(item);
                        n++;
                     end
                  end
               end
            if (n == 0) begin
               item = '0;
               item.last = 1'b1;
               hits_due.push_back(item);
            end else begin
               hits_due[hits_due.size() - 1].last = 1'b1;
            end
         end
      endcase
   endtask

   // watch the channels
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         errors = 0;
         small_rad = SMALL_RADIUS_RST;
         large_rad = LARGE_RADIUS_RST;
         foreach (list_len[i]) list_len[i] = 0;
         hits_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_SMALL_RADIUS) small_rad = csr_wdata;
            else large_rad = csr_wdata;
         end
         if (req_push && !req_full)
            grid_update(req_type, req_ent_index, req_pos_x, req_pos_y, req_ent_alive,
                        req_ent_large, req_extent_w, req_extent_h);
         if (rsp_pop && !rsp_empty) begin
            got.hit_index = rsp_hit_index;
            got.hit_valid = rsp_hit_valid;
            got.last = rsp_last;
            if (hits_due.size() == 0) begin
               if (errors < 10)
                  $display("%t: unexpected result idx=%0d valid=%0b last=%0b", $realtime,
                           got.hit_index, got.hit_valid, got.last);
               errors++;
            end else begin
               want = hits_due.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display("%t: mismatch exp idx=%0d valid=%0b last=%0b, got idx=%0d valid=%0b last=%0b",
                              $realtime, want.hit_index, want.hit_valid, want.last,
                              got.hit_index, got.hit_valid, got.last);
                  errors++;
               end
            end
         end
      end
   end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
   import ugnq_pkg::*;

   localparam int LIMIT = 5000000;
   localparam int PHASE_ITEMS = 52;

   logic               clock, reset;
   logic               req_push, req_full;
   logic [1:0]         req_type;
   logic [5:0]         req_ent_index;
   logic signed [15:0] req_pos_x, req_pos_y;
   logic               req_ent_alive, req_ent_large;
   logic [14:0]        req_extent_w, req_extent_h;
   logic               rsp_empty, rsp_pop;
   logic [5:0]         rsp_hit_index;
   logic               rsp_hit_valid, rsp_last;
   logic               csr_wr_en, csr_index;
   logic [14:0]        csr_wdata;
   int                 errors, pending, cycles;
   int                 hot_x [6];
   int                 hot_y [6];

   uniform_grid_neighbor_query DUT (.*);
   ugnq_checker u_checker (.*);

   // clock and cycle limit
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: random gaps plus a periodic long hold-off
   initial begin
      int gap, rx_cycle;
      rsp_pop = 0;
      gap = 0;
      rx_cycle = 0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle % 3000 == 0) gap = 400;
         if (gap > 0) begin
            rsp_pop = 0;
            gap--;
         end else begin
            rsp_pop = 1;
            case ($urandom_range(0, 99)) inside
               [0:64]:  gap = 0;
               [65:94]: gap = $urandom_range(1, 3);
               default: gap = $urandom_range(10, 40);
            endcase
         end
      end
   end

   // offer one request, hold it until taken, then maybe idle
   task automatic send_req(logic [1:0] op, logic [5:0] idx, int x, int y, logic alive,
                           logic big, int w, int h);
      int gap;
      req_type = op;
      req_ent_index = idx;
      req_pos_x = x[15:0];
      req_pos_y = y[15:0];
      req_ent_alive = alive;
      req_ent_large = big;
      req_extent_w = w[14:0];
      req_extent_h = h[14:0];
      req_push = 1;
      // full only changes at a rising edge, so check it between edges
      while (req_full) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      case ($urandom_range(0, 99)) inside
         [0:59]:  gap = 0;
         [60:89]: gap = $urandom_range(1, 3);
         [90:97]: gap = $urandom_range(4, 10);
         default: gap = $urandom_range(20, 60);
      endcase
      if (gap > 0) begin
         req_push = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_radii(int small_r, int large_r);
      csr_wr_en = 1;
      csr_index = CSR_SMALL_RADIUS;
      csr_wdata = small_r[14:0];
      @(negedge clock);
      csr_index = CSR_LARGE_RADIUS;
      csr_wdata = large_r[14:0];
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   // wait for every result, then let the back stage finish inserts
   task automatic drain();
      req_push = 0;
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic int pick_pos(int axis_hot);
      case ($urandom_range(0, 99)) inside
         [0:69]:  return axis_hot + $urandom_range(0, 1200) - 600;
         [70:89]: return $urandom_range(0, 16383);
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic int pick_extent();
      case ($urandom_range(0, 99)) inside
         [0:79]:  return $urandom_range(0, 3000);
         [80:94]: return $urandom_range(0, 16000);
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   task automatic random_phase(bit crowd);
      int done, k, hs;
      logic [1:0] op;
      logic alive;
      foreach (hot_x[i]) begin
         hot_x[i] = $urandom_range(0, 16383);
         hot_y[i] = $urandom_range(0, 16383);
      end
      // overfill one cell, then query it
      if (crowd) begin
         for (k = 0; k < 70; k++)
            send_req(OP_INSERT, 6'($urandom), hot_x[0] + $urandom_range(0, 100),
                     hot_y[0] + $urandom_range(0, 100), 1, 1'($urandom), 0, 0);
         send_req(OP_RADIUS, 0, hot_x[0], hot_y[0], 0, 0, 400, 0);
         send_req(OP_RECT, 0, hot_x[0], hot_y[0], 0, 0, 100, 100);
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
         hs = $urandom_range(0, 5);
         case ($urandom_range(0, 99)) inside
            [0:2]:   op = OP_CLEAR;
            [3:54]:  op = OP_INSERT;
            [55:79]: op = OP_RADIUS;
            default: op = OP_RECT;
         endcase
         alive = ($urandom_range(0, 9) != 0);
         send_req(op, 6'($urandom), pick_pos(hot_x[hs]), pick_pos(hot_y[hs]), alive,
                  1'($urandom), pick_extent(), pick_extent());
         if (!(op == OP_INSERT && !alive)) done++;
      end
      drain();
   endtask

   initial begin
      cycles = 0;
      reset = 1;
      req_push = 0;
      req_type = OP_CLEAR;
      req_ent_index = 0;
      req_pos_x = 0;
      req_pos_y = 0;
      req_ent_alive = 0;
      req_ent_large = 0;
      req_extent_w = 0;
      req_extent_h = 0;
      csr_wr_en = 0;
      csr_index = CSR_SMALL_RADIUS;
      csr_wdata = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, boundaries and special cases
      write_radii(320, 560);
      send_req(OP_RADIUS, 0, 5000, 5000, 0, 0, 1000, 0);       // no hits
      send_req(OP_INSERT, 1, 0, 0, 1, 0, 0, 0);
      send_req(OP_INSERT, 2, -32768, -32768, 1, 1, 0, 0);
      send_req(OP_INSERT, 3, 32767, 32767, 1, 0, 0, 0);
      send_req(OP_INSERT, 4, 16383, 16384, 1, 1, 0, 0);
      send_req(OP_INSERT, 5, -1, -1024, 1, 0, 0, 0);
      send_req(OP_INSERT, 6, 1024, 1023, 0, 1, 0, 0);          // not alive
      send_req(OP_INSERT, 63, 1030, 1030, 1, 1, 0, 0);
      send_req(OP_INSERT, 63, 2000, 2000, 1, 0, 0, 0);         // repeated index
      send_req(OP_RADIUS, 0, 0, 0, 0, 0, 0, 0);                // zero radius exact
      send_req(OP_RADIUS, 0, 0, 0, 0, 0, 32767, 0);
      send_req(OP_RADIUS, 0, -32768, -32768, 0, 0, 0, 0);      // empty cell range
      send_req(OP_RECT, 0, 0, 0, 0, 0, 0, 0);
      send_req(OP_RECT, 0, -32768, -32768, 0, 0, 32767, 32767);
      send_req(OP_RECT, 0, 1500, 1500, 0, 0, 1000, 32767);
      send_req(OP_RECT, 0, 32767, 32767, 0, 0, 32767, 0);
      send_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_req(OP_RECT, 0, -32768, -32768, 0, 0, 32767, 32767);
      send_req(OP_INSERT, 7, 300, 300, 1, 0, 0, 0);
      send_req(OP_RADIUS, 0, 300, 300, 0, 0, 32767, 32767);
      drain();

      // random phases over several register settings
      random_phase(0);
      write_radii(0, 0);
      random_phase(1);
      write_radii(32767, 32767);
      random_phase(0);
      write_radii($urandom_range(0, 32767), $urandom_range(0, 32767));
      random_phase(1);

      repeat (100) @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
